>>> hdl/pqtq_pkg.sv
// ----------------------------------------------------------------------------
// pqtq_pkg: shared types and constants of the periodic quantum timeout queue
// Field widths, operation and result codes, queue entry and cell command types.
// ----------------------------------------------------------------------------
package pqtq_pkg;

    localparam int TIME_W    = 64;
    localparam int THR_W     = 5;
    localparam int FUNC_W    = 2;
    localparam int KIND_W    = 2;
    localparam int STAT_W    = 2;
    localparam int PER_W     = 32;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 72;
    localparam int REM_CNT_W = 6;

    localparam logic [PER_W-1:0] PERIOD_RESET = 32'd1000000;

    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd3;

    localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEADLINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAKE     = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_QUEUED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EARLY  = 2'd3;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t CELL_HOLD   = 2'd0;
    localparam cell_op_t CELL_INSERT = 2'd1;
    localparam cell_op_t CELL_REMOVE = 2'd2;
    localparam cell_op_t CELL_POP    = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] wake_time;
        logic [THR_W-1:0]  thread;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   key;
    } cell_cmd_t;

    // Flags that ripple from a cell to its right-hand neighbor
    typedef struct packed {
        logic ahead;    // this entry sorts ahead of the key
        logic hit;      // this or an earlier cell holds the key's thread
    } cell_link_t;

endpackage

>>> hdl/pqtq_cell.sv
// ----------------------------------------------------------------------------
// pqtq_cell: one slot of the sorted timeout queue
// Holds one entry; inserts, removes or pops by trading with its neighbors.
// ----------------------------------------------------------------------------
module pqtq_cell
(
    input  logic                    clk,
    input  pqtq_pkg::cell_cmd_t     cmd,
    input  logic                    occ,
    input  pqtq_pkg::entry_t        left_entry,
    input  pqtq_pkg::cell_link_t    left_link,
    input  pqtq_pkg::entry_t        right_entry,
    output pqtq_pkg::entry_t        entry,
    output pqtq_pkg::cell_link_t    link,
    output logic                    le
);

    pqtq_pkg::entry_t entry_reg;
    pqtq_pkg::entry_t entry_next;
    logic             lt;
    logic             eq;
    logic             match;

    assign lt    = entry_reg.wake_time < cmd.key.wake_time;
    assign eq    = entry_reg.wake_time == cmd.key.wake_time;
    assign match = occ && (entry_reg.thread == cmd.key.thread);

    assign link.ahead = occ && (lt || (eq && (entry_reg.thread < cmd.key.thread)));
    assign link.hit   = left_link.hit | match;
    assign le         = lt | eq;
    assign entry      = entry_reg;

    always_comb
    begin
        unique case (cmd.op)
            pqtq_pkg::CELL_HOLD:
                entry_next = entry_reg;
            pqtq_pkg::CELL_INSERT:
            begin
                // keep, take the key, or shift right from the left neighbor
                if (link.ahead)
                    entry_next = entry_reg;
                else if (left_link.ahead)
                    entry_next = cmd.key;
                else
                    entry_next = left_entry;
            end
            pqtq_pkg::CELL_REMOVE:
                entry_next = link.hit ? right_entry : entry_reg;
            pqtq_pkg::CELL_POP:
                entry_next = right_entry;
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

>>> hdl/pqtq_rem.sv
// ----------------------------------------------------------------------------
// pqtq_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; yields dividend mod divisor.
// ----------------------------------------------------------------------------
module pqtq_rem
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pqtq_pkg::TIME_W-1:0]  dividend,
    input  logic [pqtq_pkg::PER_W-1:0]   divisor,
    output logic                         done,
    output logic [pqtq_pkg::PER_W-1:0]   remainder
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [pqtq_pkg::REM_CNT_W-1:0]    cnt_reg;
    logic [pqtq_pkg::REM_CNT_W-1:0]    cnt_next;
    logic [pqtq_pkg::TIME_W-1:0]       dvd_reg;
    logic [pqtq_pkg::TIME_W-1:0]       dvd_next;
    logic [pqtq_pkg::PER_W-1:0]        dsr_reg;
    logic [pqtq_pkg::PER_W-1:0]        dsr_next;
    logic [pqtq_pkg::PER_W-1:0]        rem_reg;
    logic [pqtq_pkg::PER_W-1:0]        rem_next;
    logic [pqtq_pkg::PER_W:0]          shifted;

    assign shifted = {rem_reg, dvd_reg[pqtq_pkg::TIME_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // bring down the next bit, subtract where it fits
            if (shifted >= {1'b0, dsr_reg})
                rem_next = pqtq_pkg::PER_W'(shifted - {1'b0, dsr_reg});
            else
                rem_next = shifted[pqtq_pkg::PER_W-1:0];
            dvd_next = {dvd_reg[pqtq_pkg::TIME_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/periodic_quantum_timeout_queue.sv
// ----------------------------------------------------------------------------
// periodic_quantum_timeout_queue: per-core timeout queue with periodic quantum
// Sorted row of queue cells, a remainder unit and a sequencer for the four ops.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation per transaction (start, add, cancel, expire);
//   m_* returns its results, tlast marking the final result of an operation.
//   cfg_* writes the quantum length; write it only while the block is idle.
// Sequencing:
//   Start, add and cancel are accepted in IDLE, then in EXEC the cell row
//   updates and the reply is loaded. An expire that is not early starts the
//   remainder unit in EXEC and waits in DIV while the bit-serial unit works
//   through the 64-bit elapsed time; its registered done flag moves the
//   sequencer to REPORT, which loads the deadline report, and POP then wakes
//   one thread per cycle while the output register is free.
// Reset:
//   Queue empty, deadline zero, quantum back to its default, output empty.
// Backpressure:
//   Results sit in an output register; a stalled receiver holds the sequencer
//   at its next result, while a new transaction can already be taken once the
//   current operation has loaded its last result.
// ----------------------------------------------------------------------------
module periodic_quantum_timeout_queue
#(
    parameter int THREADS = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: quantum length in cycles
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pqtq_pkg::PER_W-1:0]      cfg_data,
    // operations
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pqtq_pkg::S_TDATA_W-1:0]  s_tdata,  // thread_id[4:0], time_value[68:5]
    input  logic [pqtq_pkg::FUNC_W-1:0]     s_tuser,  // func[1:0]
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pqtq_pkg::M_TDATA_W-1:0]  m_tdata,  // status[1:0], woken_thread[6:2],
                                                      // time_out[70:7]
    output logic [pqtq_pkg::KIND_W-1:0]     m_tuser,  // kind[1:0]
    output logic                            m_tlast
);

    localparam int CNT_W = $clog2(THREADS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_REPORT = 3'd3;
    localparam logic [2:0] ST_POP    = 3'd4;

    logic [2:0]                        state_reg;
    logic [2:0]                        state_next;
    logic [pqtq_pkg::PER_W-1:0]        period_reg;
    logic [pqtq_pkg::FUNC_W-1:0]       func_reg;
    logic [pqtq_pkg::THR_W-1:0]        tid_reg;
    logic [pqtq_pkg::TIME_W-1:0]       tv_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [THREADS-1:0]                pend_reg;
    logic [THREADS-1:0]                pend_next;
    logic [pqtq_pkg::TIME_W-1:0]       deadline_reg;
    logic [pqtq_pkg::TIME_W-1:0]       deadline_next;

    logic                              m_tvalid_reg;
    logic [pqtq_pkg::M_TDATA_W-1:0]    m_tdata_reg;
    logic [pqtq_pkg::KIND_W-1:0]       m_tuser_reg;
    logic                              m_tlast_reg;

    logic                              out_free;
    logic                              emit;
    logic [pqtq_pkg::KIND_W-1:0]       o_kind;
    logic [pqtq_pkg::STAT_W-1:0]       o_status;
    logic [pqtq_pkg::THR_W-1:0]        o_thr;
    logic [pqtq_pkg::TIME_W-1:0]       o_time;
    logic                              o_last;

    logic [pqtq_pkg::PER_W-1:0]        per_eff;
    logic [pqtq_pkg::TIME_W:0]         start_sum;
    logic [pqtq_pkg::TIME_W-1:0]       start_dl;
    logic [pqtq_pkg::TIME_W:0]         exp_sum;
    logic [pqtq_pkg::TIME_W-1:0]       exp_dl;
    logic                              rem_start;
    logic                              rem_done;
    logic [pqtq_pkg::PER_W-1:0]        rem_val;

    logic [THREADS-1:0]                tid_dec;
    logic [THREADS-1:0]                head_dec;
    logic                              tid_oor;
    logic                              tid_pend;
    logic                              q_full;
    logic                              head_due;
    logic                              second_due;

    pqtq_pkg::cell_op_t                cmd_op;
    pqtq_pkg::cell_cmd_t               cmd;
    pqtq_pkg::entry_t                  cell_entry [THREADS];
    pqtq_pkg::cell_link_t              cell_link  [THREADS];
    logic [THREADS-1:0]                cell_le;
    logic [THREADS-1:0]                occ;

    // ------------------------------------------------------------------------
    // Configuration: always ready, single register
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= pqtq_pkg::PERIOD_RESET;
        else if (cfg_valid && cfg_ready)
            period_reg <= cfg_data;
    end

    // a zero quantum acts as a quantum of one
    assign per_eff = (period_reg == '0) ? pqtq_pkg::PER_W'(1) : period_reg;

    // ------------------------------------------------------------------------
    // Operand capture
    // ------------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= s_tuser;
            tid_reg  <= s_tdata[pqtq_pkg::THR_W-1:0];
            tv_reg   <= s_tdata[pqtq_pkg::THR_W +: pqtq_pkg::TIME_W];
        end
    end

    // ------------------------------------------------------------------------
    // Cell row: sorted by wake time, then thread; slot i holds an entry when
    // i is below the fill count
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < THREADS; i++)
        begin
            occ[i]      = count_reg > CNT_W'(i);
            tid_dec[i]  = 32'(tid_reg) == i;
            head_dec[i] = 32'(cell_entry[0].thread) == i;
        end
    end

    assign cmd.op            = cmd_op;
    assign cmd.key.wake_time = tv_reg;
    assign cmd.key.thread    = tid_reg;

    for (genvar g = 0; g < THREADS; g++)
    begin : g_cell
        pqtq_pkg::entry_t     left_e;
        pqtq_pkg::cell_link_t left_l;
        pqtq_pkg::entry_t     right_e;

        if (g == 0)
        begin : g_head
            assign left_e = cmd.key;
            assign left_l = '{ahead: 1'b1, hit: 1'b0};
        end
        else
        begin : g_body
            assign left_e = cell_entry[g-1];
            assign left_l = cell_link[g-1];
        end

        if (g == THREADS - 1)
        begin : g_tail
            assign right_e = cell_entry[g];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[g+1];
        end

        pqtq_cell u_cell
        (
            .clk         (clk),
            .cmd         (cmd),
            .occ         (occ[g]),
            .left_entry  (left_e),
            .left_link   (left_l),
            .right_entry (right_e),
            .entry       (cell_entry[g]),
            .link        (cell_link[g]),
            .le          (cell_le[g])
        );
    end

    // ------------------------------------------------------------------------
    // Remainder of elapsed time over the quantum
    // ------------------------------------------------------------------------
    pqtq_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (tv_reg - deadline_reg),
        .divisor   (per_eff),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // saturating deadline sums
    assign start_sum = {1'b0, tv_reg} + (pqtq_pkg::TIME_W + 1)'(per_eff);
    assign start_dl  = start_sum[pqtq_pkg::TIME_W] ? '1 : start_sum[pqtq_pkg::TIME_W-1:0];
    assign exp_sum   = {1'b0, tv_reg} + (pqtq_pkg::TIME_W + 1)'(per_eff - rem_val);
    assign exp_dl    = exp_sum[pqtq_pkg::TIME_W] ? '1 : exp_sum[pqtq_pkg::TIME_W-1:0];

    assign tid_oor    = 32'(tid_reg) >= THREADS;
    assign tid_pend   = |(pend_reg & tid_dec);
    assign q_full     = count_reg == CNT_W'(THREADS);
    assign head_due   = occ[0] && cell_le[0];
    assign second_due = occ[1] && cell_le[1];

    assign out_free = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        deadline_next = deadline_reg;
        cmd_op        = pqtq_pkg::CELL_HOLD;
        rem_start     = 1'b0;
        emit          = 1'b0;
        o_kind        = pqtq_pkg::KIND_REPLY;
        o_status      = pqtq_pkg::STAT_OK;
        o_thr         = '0;
        o_time        = '0;
        o_last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                unique case (func_reg)
                    pqtq_pkg::FUNC_START:
                    begin
                        if (out_free)
                        begin
                            emit          = 1'b1;
                            o_kind        = pqtq_pkg::KIND_DEADLINE;
                            o_time        = start_dl;
                            deadline_next = start_dl;
                            count_next    = '0;
                            pend_next     = '0;
                            state_next    = ST_IDLE;
                        end
                    end
                    pqtq_pkg::FUNC_ADD:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (tid_oor || q_full)
                                o_status = pqtq_pkg::STAT_FULL;
                            else if (tid_pend)
                                o_status = pqtq_pkg::STAT_QUEUED;
                            else
                            begin
                                cmd_op     = pqtq_pkg::CELL_INSERT;
                                count_next = count_reg + 1'b1;
                                pend_next  = pend_reg | tid_dec;
                            end
                        end
                    end
                    pqtq_pkg::FUNC_CANCEL:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (!tid_oor && tid_pend)
                            begin
                                cmd_op     = pqtq_pkg::CELL_REMOVE;
                                count_next = count_reg - 1'b1;
                                pend_next  = pend_reg & ~tid_dec;
                            end
                        end
                    end
                    pqtq_pkg::FUNC_EXPIRE:
                    begin
                        if (tv_reg < deadline_reg)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                o_status   = pqtq_pkg::STAT_EARLY;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            rem_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_DIV:
            begin
                if (rem_done)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    o_kind        = pqtq_pkg::KIND_DEADLINE;
                    o_time        = exp_dl;
                    deadline_next = exp_dl;
                    o_last        = !head_due;
                    state_next    = head_due ? ST_POP : ST_IDLE;
                end
            end
            ST_POP:
            begin
                // wake the head entry and shift the row left
                if (out_free)
                begin
                    emit       = 1'b1;
                    o_kind     = pqtq_pkg::KIND_WAKE;
                    o_thr      = cell_entry[0].thread;
                    o_time     = tv_reg;
                    o_last     = !second_due;
                    cmd_op     = pqtq_pkg::CELL_POP;
                    count_next = count_reg - 1'b1;
                    pend_next  = pend_reg & ~head_dec;
                    state_next = second_due ? ST_POP : ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= '0;
            deadline_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            deadline_reg <= deadline_next;
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= {1'b0, o_time, o_thr, o_status};
            m_tuser_reg <= o_kind;
            m_tlast_reg <= o_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(THREADS))
        else $error("queue fill count above capacity");

    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pend_reg) == 32'(count_reg))
        else $error("pending bits disagree with fill count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |-> count_reg != '0)
        else $error("wakeup with empty queue");

    a_rem_done_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == ST_DIV)
        else $error("remainder finished outside divide wait");

endmodule
